### src/gsf_pkg.sv
// Shared types and constants for the 3x3 glyph smoothing filter.
// Used by gsf_line_mem, gsf_divider and glyph_3x3_smoothing_filter.
package gsf_pkg;

  // Default geometry limits
  localparam int unsigned MAX_WIDTH_DEF  = 512;
  localparam int unsigned MAX_HEIGHT_DEF = 512;

  // Fixed field widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned WEIGHT_W   = 8;
  localparam int unsigned DIM_W      = 10;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // centre + 4*edge + 4*corner, at most 2295
  localparam int unsigned DIVISOR_W = 12;
  // weighted sum plus rounding half, at most 586372
  localparam int unsigned SUM_W     = 20;
  // quotient never exceeds 255
  localparam int unsigned QUOT_W    = 8;

  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned CNT_W       = 2;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER = 3'd0,
    REG_EDGE   = 3'd1,
    REG_CORNER = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_HEIGHT = 3'd4,
    REG_EXPAND = 3'd5
  } cfg_idx_e;

endpackage

### src/gsf_line_mem.sv
// Line store of the smoothing filter: three source rows in one RAM.
// One write port, one read port, read data registered. Uses gsf_pkg.
module gsf_line_mem #(
  parameter int unsigned DEPTH = 3 * gsf_pkg::MAX_WIDTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [gsf_pkg::PIX_W-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [gsf_pkg::PIX_W-1:0] rdata_o
);

  logic [gsf_pkg::PIX_W-1:0] mem_q [DEPTH];
  logic [gsf_pkg::PIX_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/gsf_divider.sv
// Restoring divider for the smoothing filter, one quotient bit a cycle.
// Quotient is known to fit in QUOT_W bits. Uses gsf_pkg.
module gsf_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gsf_pkg::SUM_W-1:0]     dividend_i,
  input  logic [gsf_pkg::DIVISOR_W-1:0] divisor_i,
  output logic                          done_o,
  output logic [gsf_pkg::QUOT_W-1:0]    quot_o
);

  localparam int unsigned SW = gsf_pkg::SUM_W;
  localparam int unsigned QW = gsf_pkg::QUOT_W;
  localparam int unsigned STEP_W = $clog2(QW);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SW-1:0]     rem_q, rem_d;
  logic [SW-1:0]     dsh_q, dsh_d;
  logic [QW-1:0]     q_q, q_d;
  logic              ge;

  assign ge = rem_q >= dsh_q;

  // one trial subtraction per cycle, divisor shifted right each step
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    q_d    = q_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(QW - 1);
      rem_d  = dividend_i;
      dsh_d  = SW'({divisor_i, {(QW-1){1'b0}}});
      q_d    = '0;
    end else if (busy_q) begin
      q_d   = {q_q[QW-2:0], ge};
      rem_d = ge ? rem_q - dsh_q : rem_q;
      dsh_d = dsh_q >> 1;
      step_d = step_q - STEP_W'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    q_q   <= q_d;
  end

  assign done_o = busy_q && (step_q == '0);
  assign quot_o = q_q;

endmodule

### src/glyph_3x3_smoothing_filter.sv
// Top level of the 3x3 glyph smoothing filter: control, window gather,
// counters and output register. Uses gsf_pkg, gsf_line_mem, gsf_divider.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries one word per source
//    pixel or drain tick. Pixels arrive in raster order; drain ticks flush
//    outputs pending after the last pixel, up to three per word.
//  - Output channel (out_valid_o / out_stall_i) gives smoothed pixels in
//    destination raster order with their column, row and last flag.
//  - Configuration (cfg_valid_i / cfg_ready_o) writes weights and geometry;
//    the user writes only while the block is idle, as the block itself
//    does not enforce it. A geometry write restarts the image.
//  - Each input word is accepted in the idle state and then checked for
//    pending results. Every result takes a check, nine tap steps that
//    read in-bounds taps through the single read port, a sum step, eight
//    divider steps and a hand-over to the output register.
//  - Reset clears counters and restores register defaults; the line
//    store needs no clearing as no unwritten entry is ever read.
//  - A stalled output holds its word; the block waits in its hand-over
//    step until the output register frees, then carries on.
module glyph_3x3_smoothing_filter #(
  parameter int unsigned MAX_WIDTH  = gsf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = gsf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input words
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           operation_i,
  input  logic [gsf_pkg::PIX_W-1:0]      pixel_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [gsf_pkg::PIX_W-1:0]      value_o,
  output logic [gsf_pkg::COORD_W-1:0]    out_x_o,
  output logic [gsf_pkg::COORD_W-1:0]    out_y_o,
  output logic                           last_pixel_o,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gsf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gsf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned XW  = $clog2(MAX_WIDTH + 3);
  localparam int unsigned YW  = $clog2(MAX_HEIGHT + 3);
  localparam int unsigned MEM_DEPTH = 3 * MAX_WIDTH;
  localparam int unsigned AW  = $clog2(MEM_DEPTH);
  localparam int unsigned WW  = gsf_pkg::WEIGHT_W;
  localparam int unsigned PW  = gsf_pkg::PIX_W;
  localparam int unsigned SW  = gsf_pkg::SUM_W;
  localparam int unsigned DVW = gsf_pkg::DIVISOR_W;
  localparam int unsigned DW  = gsf_pkg::DIM_W;
  localparam int unsigned CW  = gsf_pkg::CNT_W;
  localparam logic signed [XW:0] X_ONE = 1;
  localparam logic signed [YW:0] Y_ONE = 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_TAP   = 6'b000100,
    ST_SUM   = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  // v mod 3 for a 3-bit value
  function automatic logic [1:0] mod3(input logic [2:0] v);
    logic [1:0] r;
    case (v)
      3'd0, 3'd3, 3'd6: r = 2'd0;
      3'd1, 3'd4, 3'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // Configuration registers
  logic [WW-1:0] cw_q, ew_q, kw_q;
  logic [DW-1:0] iw_q, ih_q;
  logic          em_q;
  logic          geo_wr;

  // Control and counters
  state_e        state_q, state_d;
  logic [XW-1:0] in_col_q, in_col_d;
  logic [YW-1:0] in_row_q, in_row_d;
  logic [1:0]    irm3_q, irm3_d;
  logic [XW-1:0] ox_q, ox_d;
  logic [YW-1:0] oy_q, oy_d;
  logic [1:0]    sym3_q, sym3_d;
  logic [CW-1:0] count_q, count_d;
  logic [1:0]    dx_q, dx_d, dy_q, dy_d;

  // Window accumulation
  logic          pend_q, pend_d;
  logic          pinb_q, pinb_d;
  logic [WW-1:0] pw_q, pw_d;
  logic [SW-1:0] acc_q, acc_d;

  // Output register
  logic          out_valid_q, out_valid_d;
  logic [PW-1:0] value_q;
  logic [XW-1:0] oxr_q;
  logic [YW-1:0] oyr_q;
  logic          last_q;
  logic          out_load;

  // Geometry
  logic [XW-1:0] w, wo;
  logic [YW-1:0] h, ho;
  logic [DVW-1:0] divisor;
  logic signed [XW:0] w_s, sx, nc, xs;
  logic signed [YW:0] h_s, sy, nr, ys;
  logic          ready, ring, last_d, in_acc, tap_inb, tap_last;
  logic [WW-1:0] tap_w;
  logic [1:0]    tap_bank;

  // Memory and divider hookup
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [PW-1:0] mem_rdata;
  logic          div_start, div_done;
  logic [gsf_pkg::QUOT_W-1:0] quot;

  assign cfg_ready_o = 1'b1;
  assign geo_wr = cfg_valid_i &&
                  (cfg_index_i == gsf_pkg::REG_WIDTH ||
                   cfg_index_i == gsf_pkg::REG_HEIGHT ||
                   cfg_index_i == gsf_pkg::REG_EXPAND);

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q <= WW'(4);
      ew_q <= WW'(2);
      kw_q <= WW'(1);
      iw_q <= DW'(16);
      ih_q <= DW'(16);
      em_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gsf_pkg::REG_CENTER: cw_q <= cfg_data_i[WW-1:0];
        gsf_pkg::REG_EDGE:   ew_q <= cfg_data_i[WW-1:0];
        gsf_pkg::REG_CORNER: kw_q <= cfg_data_i[WW-1:0];
        gsf_pkg::REG_WIDTH:  iw_q <= cfg_data_i[DW-1:0];
        gsf_pkg::REG_HEIGHT: ih_q <= cfg_data_i[DW-1:0];
        gsf_pkg::REG_EXPAND: em_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamped geometry and divisor
  always_comb begin
    if (iw_q == '0) begin
      w = XW'(1);
    end else if (32'(iw_q) > MAX_WIDTH) begin
      w = XW'(MAX_WIDTH);
    end else begin
      w = XW'(iw_q);
    end
    if (ih_q == '0) begin
      h = YW'(1);
    end else if (32'(ih_q) > MAX_HEIGHT) begin
      h = YW'(MAX_HEIGHT);
    end else begin
      h = YW'(ih_q);
    end
  end

  assign wo  = w + {em_q, 1'b0};
  assign ho  = h + {em_q, 1'b0};
  assign w_s = $signed({1'b0, w});
  assign h_s = $signed({1'b0, h});
  assign divisor = DVW'(cw_q) + DVW'({ew_q, 2'b00}) + DVW'({kw_q, 2'b00});

  // Source position of the current output and its readiness
  assign sx = $signed({1'b0, ox_q}) - $signed((XW+1)'(em_q));
  assign sy = $signed({1'b0, oy_q}) - $signed((YW+1)'(em_q));
  assign nc = (sx + X_ONE > w_s - X_ONE) ? w_s - X_ONE : sx + X_ONE;
  assign nr = (sy + Y_ONE > h_s - Y_ONE) ? h_s - Y_ONE : sy + Y_ONE;
  assign ready = (nr < $signed({1'b0, in_row_q})) ||
                 (nr == $signed({1'b0, in_row_q}) &&
                  nc < $signed({1'b0, in_col_q}));
  assign ring  = (sx <= 0) || (sx >= w_s - 1) || (sy <= 0) || (sy >= h_s - 1);
  assign last_d = (ox_q == wo - XW'(1)) && (oy_q == ho - YW'(1));

  // Current tap of the 3x3 window
  assign xs = sx + $signed((XW+1)'(dx_q)) - $signed((XW+1)'(1));
  assign ys = sy + $signed((YW+1)'(dy_q)) - $signed((YW+1)'(1));
  assign tap_inb  = (xs >= 0) && (xs < w_s) && (ys >= 0) && (ys < h_s);
  assign tap_last = (dx_q == 2'd2) && (dy_q == 2'd2);
  assign tap_bank = mod3(3'(sym3_q) + 3'(dy_q) + 3'd2);
  always_comb begin
    if (dx_q == 2'd1 && dy_q == 2'd1) begin
      tap_w = cw_q;
    end else if (dx_q == 2'd1 || dy_q == 2'd1) begin
      tap_w = ew_q;
    end else begin
      tap_w = kw_q;
    end
  end

  // Line store write on pixel acceptance, reads while gathering taps
  assign in_acc    = in_valid_i && !in_stall_o;
  assign mem_we    = in_acc && (operation_i == gsf_pkg::OP_PIXEL) && (in_row_q < h);
  assign mem_waddr = AW'(irm3_q) * AW'(MAX_WIDTH) + AW'(in_col_q);
  assign mem_re    = (state_q == ST_TAP) && tap_inb;
  assign mem_raddr = AW'(tap_bank) * AW'(MAX_WIDTH) + AW'(xs[XW-1:0]);

  gsf_line_mem #(
    .DEPTH (MEM_DEPTH)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (pixel_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign div_start = (state_q == ST_SUM);

  gsf_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_d),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  // Sequencer and counters
  always_comb begin
    state_d  = state_q;
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    irm3_d   = irm3_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    sym3_d   = sym3_q;
    count_d  = count_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    pend_d   = 1'b0;
    pinb_d   = tap_inb;
    pw_d     = tap_w;
    acc_d    = acc_q;

    // fold in the tap read last cycle
    if (pend_q && pinb_q) begin
      acc_d = acc_q + SW'(pw_q) * SW'(mem_rdata);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          count_d = '0;
          state_d = ST_CHECK;
          if (mem_we) begin
            if (in_col_q + XW'(1) >= w) begin
              in_col_d = '0;
              in_row_d = in_row_q + YW'(1);
              irm3_d   = (irm3_q == 2'd2) ? 2'd0 : irm3_q + 2'd1;
            end else begin
              in_col_d = in_col_q + XW'(1);
            end
          end
        end
      end
      ST_CHECK: begin
        if (32'(count_q) < gsf_pkg::MAX_RESULTS && oy_q < ho && ready) begin
          acc_d   = ring ? SW'(divisor >> 1) : '0;
          dx_d    = 2'd0;
          dy_d    = 2'd0;
          state_d = ST_TAP;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_TAP: begin
        pend_d = 1'b1;
        if (tap_last) begin
          state_d = ST_SUM;
        end else if (dx_q == 2'd2) begin
          dx_d = 2'd0;
          dy_d = dy_q + 2'd1;
        end else begin
          dx_d = dx_q + 2'd1;
        end
      end
      ST_SUM: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          count_d = count_q + CW'(1);
          if (last_d) begin
            in_col_d = '0;
            in_row_d = '0;
            irm3_d   = 2'd0;
            ox_d     = '0;
            oy_d     = '0;
            sym3_d   = em_q ? 2'd2 : 2'd0;
            state_d  = ST_IDLE;
          end else begin
            state_d = ST_CHECK;
            if (ox_q == wo - XW'(1)) begin
              ox_d   = '0;
              oy_d   = oy_q + YW'(1);
              sym3_d = (sym3_q == 2'd2) ? 2'd0 : sym3_q + 2'd1;
            end else begin
              ox_d = ox_q + XW'(1);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // geometry write restarts the image
    if (geo_wr) begin
      in_col_d = '0;
      in_row_d = '0;
      irm3_d   = 2'd0;
      ox_d     = '0;
      oy_d     = '0;
      if (cfg_index_i == gsf_pkg::REG_EXPAND) begin
        sym3_d = cfg_data_i[0] ? 2'd2 : 2'd0;
      end else begin
        sym3_d = em_q ? 2'd2 : 2'd0;
      end
    end
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_col_q    <= '0;
      in_row_q    <= '0;
      irm3_q      <= 2'd0;
      ox_q        <= '0;
      oy_q        <= '0;
      sym3_q      <= 2'd0;
      count_q     <= '0;
      dx_q        <= 2'd0;
      dy_q        <= 2'd0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      irm3_q      <= irm3_d;
      ox_q        <= ox_d;
      oy_q        <= oy_d;
      sym3_q      <= sym3_d;
      count_q     <= count_d;
      dx_q        <= dx_d;
      dy_q        <= dy_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pinb_q <= pinb_d;
    pw_q   <= pw_d;
    acc_q  <= acc_d;
    if (out_load) begin
      value_q <= (divisor == '0) ? '0 : quot;
      oxr_q   <= ox_q;
      oyr_q   <= oy_q;
      last_q  <= last_d;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign out_x_o      = gsf_pkg::COORD_W'(oxr_q);
  assign out_y_o      = gsf_pkg::COORD_W'(oyr_q);
  assign last_pixel_o = last_q;

  // Checks
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide step");

  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_d) |=> (ox_q == '0 && oy_q == '0 && in_row_q == '0))
    else $error("counters not cleared after the final output");

  a_pend_from_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(state_q) == ST_TAP)
    else $error("window tap pending without a tap read");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
    else $error("output raised outside the hand-over step");

endmodule
